### src/look_around_sequencer_top_assert.svh
// Assertion macros shared by the checker of the scan sequencer.
`ifndef LOOK_AROUND_SEQUENCER_TOP_ASSERT_SVH
`define LOOK_AROUND_SEQUENCER_TOP_ASSERT_SVH

// Checks a property on every clock edge while reset is low.
`define LAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checks a property on every clock edge, during reset too.
`define LAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### src/las_pkg.sv
// Types, codes and helper functions of the look-around scan sequencer.
package las_pkg;

  // Width of the table index and the number of table entries in use.
  localparam int IDX_W      = 3;
  localparam int MAX_ANGLES = 4;
  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(MAX_ANGLES);
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam int TIME_W  = 16;
  localparam int ELAP_W  = 10;
  localparam int ANGLE_W = 13;
  localparam int DELTA_W = 14;
  localparam int COUNT_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Operation codes of a command word.
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_FORCE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Phase codes as they appear in a result word.
  localparam logic [1:0] PHASE_CODE_START    = 2'd0;
  localparam logic [1:0] PHASE_CODE_MOVING   = 2'd1;
  localparam logic [1:0] PHASE_CODE_PAUSE    = 2'd2;
  localparam logic [1:0] PHASE_CODE_COMPLETE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_ZERO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THREE = 3'd6;

  typedef enum logic [3:0] {
    PH_START    = 4'b0001,
    PH_MOVING   = 4'b0010,
    PH_PAUSE    = 4'b0100,
    PH_COMPLETE = 4'b1000
  } phase_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_START:    code = PHASE_CODE_START;
      PH_MOVING:   code = PHASE_CODE_MOVING;
      PH_PAUSE:    code = PHASE_CODE_PAUSE;
      PH_COMPLETE: code = PHASE_CODE_COMPLETE;
      default:     code = PHASE_CODE_START;
    endcase
    return code;
  endfunction

  // Reads one entry of the look-angle table; entries past the table read as zero.
  function automatic logic signed [ANGLE_W-1:0] tab_read(
    input logic [IDX_W-1:0]          idx,
    input logic signed [ANGLE_W-1:0] a0,
    input logic signed [ANGLE_W-1:0] a1,
    input logic signed [ANGLE_W-1:0] a2,
    input logic signed [ANGLE_W-1:0] a3
  );
    logic signed [ANGLE_W-1:0] val;
    case (idx)
      3'd0:    val = a0;
      3'd1:    val = a1;
      3'd2:    val = a2;
      3'd3:    val = a3;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### src/las_if.sv
// Command and result channel interfaces of the scan sequencer.
interface las_cmd_if;
  import las_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ELAP_W-1:0] elapsed;

  modport source (output valid, op, elapsed, input ready);
  modport sink (input valid, op, elapsed, output ready);
endinterface

interface las_res_if;
  import las_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                phase;
  logic                      turn_valid;
  logic signed [DELTA_W-1:0] turn_delta;
  logic                      stop_drive;
  logic                      controller_reset;

  modport source (output valid, phase, turn_valid, turn_delta, stop_drive,
                  controller_reset, input ready);
  modport sink (input valid, phase, turn_valid, turn_delta, stop_drive,
                controller_reset, output ready);
endinterface

### src/look_around_sequencer_top.sv
// Top level of the look-around scan sequencer.
//
//   Channel  Dir  Handshake          Contents
//   cmd      in   valid/ready        op, elapsed
//   res      out  valid/ready        phase, turn_valid, turn_delta, stop_drive,
//                                    controller_reset
//   cfg      in   cfg_we             cfg_index, cfg_data (write only)
//
// Each accepted command word has its result word shown in the next cycle, so
// a new word can be accepted on every clock edge while res is not stalled.
// The step logic is one timer subtract-and-compare plus one table difference,
// all between the sequencer state and the result register.
// Reset is synchronous and active high; it restores the configuration defaults
// and puts the sequencer in the start phase with a zero index and timer.
// A stalled result word holds in the result register; cmd.ready stays high as
// long as that register is empty or is being taken in the same cycle.
module look_around_sequencer_top
  import las_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  las_cmd_if.sink               cmd,
  las_res_if.source             res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [TIME_W-1:0]         move_time;
  logic [TIME_W-1:0]         pause_time;
  logic [COUNT_W-1:0]        angle_count;
  logic signed [ANGLE_W-1:0] angle_zero;
  logic signed [ANGLE_W-1:0] angle_one;
  logic signed [ANGLE_W-1:0] angle_two;
  logic signed [ANGLE_W-1:0] angle_three;

  // Sequencer state.
  phase_t            phase_reg;
  phase_t            phase_next;
  logic [IDX_W-1:0]  angle_index;
  logic [IDX_W-1:0]  angle_index_next;
  logic [TIME_W-1:0] time_left;
  logic [TIME_W-1:0] time_left_next;

  // Result of the word being accepted.
  logic                      turn_valid_next;
  logic signed [DELTA_W-1:0] turn_delta_next;
  logic                      stop_drive_next;
  logic                      controller_reset_next;

  logic accept;

  // The result register is the only buffer; a word may enter whenever it is
  // free or is being drained in this cycle.
  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_time   <= TIME_W'(1000);
      pause_time  <= TIME_W'(500);
      angle_count <= COUNT_W'(4);
      angle_zero  <= ANGLE_W'(300);
      angle_one   <= -ANGLE_W'(300);
      angle_two   <= ANGLE_W'(600);
      angle_three <= -ANGLE_W'(600);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOVE_TIME:   move_time   <= cfg_data;
        REG_PAUSE_TIME:  pause_time  <= cfg_data;
        REG_ANGLE_COUNT: angle_count <= cfg_data[COUNT_W-1:0];
        REG_ANGLE_ZERO:  angle_zero  <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_ONE:   angle_one   <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_TWO:   angle_two   <= cfg_data[ANGLE_W-1:0];
        REG_ANGLE_THREE: angle_three <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // One sequencer step. The timer counts down first, saturating at zero, and
  // then the operation runs on the counted-down value.
  always_comb begin
    logic [TIME_W-1:0]         elapsed_ext;
    logic [IDX_W-1:0]          idx_inc;
    logic signed [ANGLE_W-1:0] cur_angle;
    logic signed [ANGLE_W-1:0] prev_angle;

    elapsed_ext = {{(TIME_W-ELAP_W){1'b0}}, cmd.elapsed};
    time_left_next = (time_left > elapsed_ext) ? (time_left - elapsed_ext) : '0;
    phase_next            = phase_reg;
    angle_index_next      = angle_index;
    turn_valid_next       = 1'b0;
    turn_delta_next       = '0;
    stop_drive_next       = 1'b0;
    controller_reset_next = 1'b0;
    idx_inc    = '0;
    cur_angle  = '0;
    prev_angle = '0;

    case (cmd.op)
      OP_FORCE: begin
        // Forced move: the index saturates instead of wrapping.
        phase_next = PH_MOVING;
        if (angle_index != IDX_MAX) begin
          angle_index_next = angle_index + IDX_W'(1);
        end
        time_left_next        = move_time;
        controller_reset_next = 1'b1;
      end
      OP_RESTART: begin
        // Restart keeps the timer as counted down.
        phase_next            = PH_START;
        angle_index_next      = '0;
        controller_reset_next = 1'b1;
      end
      OP_STEP: begin
        if (phase_reg == PH_START) begin
          phase_next            = PH_MOVING;
          time_left_next        = move_time;
          angle_index_next      = '0;
          controller_reset_next = 1'b1;
        end
        if (time_left_next == '0) begin
          controller_reset_next = 1'b1;
          if (phase_next == PH_PAUSE) begin
            phase_next     = PH_MOVING;
            time_left_next = move_time;
            idx_inc        = angle_index_next + IDX_W'(1);
            angle_index_next = (idx_inc > angle_count) ? '0 : idx_inc;
          end else if (phase_next == PH_MOVING) begin
            phase_next     = PH_PAUSE;
            time_left_next = pause_time;
          end
          if (angle_index_next >= angle_count ||
              {1'b0, angle_index_next} >= IDX_LIMIT) begin
            phase_next = PH_COMPLETE;
          end
        end
        if (phase_next == PH_MOVING) begin
          turn_valid_next = 1'b1;
          // Past the table the turn is still issued, with a zero delta.
          if ({1'b0, angle_index_next} < IDX_LIMIT) begin
            cur_angle = tab_read(angle_index_next, angle_zero, angle_one,
                                 angle_two, angle_three);
            if (angle_index_next != '0) begin
              prev_angle = tab_read(angle_index_next - IDX_W'(1), angle_zero,
                                    angle_one, angle_two, angle_three);
            end
            turn_delta_next = DELTA_W'(cur_angle) - DELTA_W'(prev_angle);
          end
        end else begin
          stop_drive_next = 1'b1;
        end
      end
      default: ;  // no operation: only the timer counts down
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_START;
      angle_index <= '0;
      time_left   <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase_reg   <= phase_next;
        angle_index <= angle_index_next;
        time_left   <= time_left_next;
        res.valid   <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Result payload; it only changes when a new word is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      res.phase            <= phase_code(phase_next);
      res.turn_valid       <= turn_valid_next;
      res.turn_delta       <= turn_delta_next;
      res.stop_drive       <= stop_drive_next;
      res.controller_reset <= controller_reset_next;
    end
  end

endmodule

### src/las_checker.sv
// Port-level checker for the scan sequencer and its bind to the top level.
`include "look_around_sequencer_top_assert.svh"

module las_checker
  import las_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                phase,
  input logic                      turn_valid,
  input logic signed [DELTA_W-1:0] turn_delta,
  input logic                      stop_drive
);

  // A turn and a stop are never commanded in the same word.
  `LAS_ASSERT(a_turn_or_stop, out_valid |-> !(turn_valid && stop_drive), "turn and stop together")

  // Turns are only issued in the moving phase.
  `LAS_ASSERT(a_turn_moving, out_valid && turn_valid |-> phase == PHASE_CODE_MOVING, "turn outside moving")

  // A word without a turn carries a zero delta.
  `LAS_ASSERT(a_no_turn_zero, out_valid && !turn_valid |-> turn_delta == '0, "delta without turn")

  // A stalled result word holds.
  `LAS_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(turn_delta), "stalled word changed")

  // Reset empties the result register.
  `LAS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind look_around_sequencer_top las_checker u_las_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .phase      (res.phase),
  .turn_valid (res.turn_valid),
  .turn_delta (res.turn_delta),
  .stop_drive (res.stop_drive)
);
